// ----- src/crcwd_pkg.sv -----
// ----------------------------------------------------------------------------
// crcwd_pkg
// Types, constants and the CRC-8 byte update shared by the word deframer.
// ----------------------------------------------------------------------------
package crcwd_pkg;

  // crc-8, polynomial 0x31, init 0xff, no reflection, no final xor
  localparam logic [7:0]  CRC_INIT      = 8'hFF;
  localparam logic [7:0]  CRC_POLY      = 8'h31;
  localparam logic [7:0]  CRC_MSB       = 8'h80;

  // not-available sentinels for unsigned and signed words
  localparam logic [15:0] SENT_UNSIGNED = 16'hFFFF;
  localparam logic [15:0] SENT_SIGNED   = 16'h7FFF;

  // position of a byte within its three-byte group
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  // one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  // one decoded word
  typedef struct packed {
    logic [2:0]  word_index;
    logic [15:0] word_value;
    logic        crc_ok;
    logic        not_available;
    logic        frame_last;
    logic        frame_ok;
  } out_item_t;

  // byte-wide crc update, eight shift steps unrolled
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/crc_word_response_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// crc_word_response_deframer_unit
// Splits a byte stream into CRC-8 protected 16-bit words and checks each one.
// ----------------------------------------------------------------------------
// Takes one response byte per item and groups bytes in threes: high data
// byte, low data byte, CRC-8 (poly 0x31, init 0xff). On the CRC byte of a group one
// item leaves with the word, its index, the CRC check, the not-available
// flag (0xffff below FIRST_SIGNED_WORD, 0x7fff from there on) and, on the
// last word of a frame, whether every CRC in the frame passed. frame_start
// restarts the group and word counters. The byte-wide CRC update and the
// compare sit between the group state registers and a single result
// register, so a byte is taken in every cycle unless a result is held by
// out_stall. Results appear in the cycle after their byte is taken.
// ----------------------------------------------------------------------------
module crc_word_response_deframer_unit #(
  parameter int WORDS_PER_FRAME   = 8,
  parameter int FIRST_SIGNED_WORD = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crcwd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crcwd_pkg::out_item_t out_data
);
  import crcwd_pkg::*;

  localparam int CNT_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
  localparam int EXT_W = 6;
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(WORDS_PER_FRAME - 1);
  localparam logic [EXT_W-1:0] FIRST_SGN = EXT_W'(FIRST_SIGNED_WORD);

  // group state
  phase_t           phase_r,  phase_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [7:0]       high_r,   high_nxt;
  logic [7:0]       low_r,    low_nxt;
  logic [7:0]       crc_r,    crc_nxt;
  logic             err_r,    err_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r,  out_data_nxt;

  // working signals
  logic             accept;
  logic             emit;
  phase_t           phase_eff;
  logic [CNT_W-1:0] count_eff;
  logic             err_eff;
  logic [EXT_W-1:0] count_ext;
  logic [15:0]      word;
  logic             ok;
  logic             last;

  // output register frees up when it is empty or being taken
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // frame start drops any partial group and the frame error flag
  always_comb begin
    phase_eff = in_data.frame_start ? PH_HIGH : phase_r;
    count_eff = in_data.frame_start ? '0 : count_r;
    err_eff   = in_data.frame_start ? 1'b0 : err_r;
  end

  // next byte phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_eff)
        PH_LOW:  phase_nxt = PH_CRC;
        PH_CRC:  phase_nxt = PH_HIGH;
        default: phase_nxt = PH_LOW;
      endcase
    end
  end

  // word assembly and checks
  always_comb begin
    count_ext = EXT_W'(count_eff);
    word      = {high_r, low_r};
    ok        = (crc_r == in_data.rx_byte);
    last      = (count_eff == LAST_CNT);
    emit      = accept && (phase_eff == PH_CRC);

    high_nxt  = high_r;
    low_nxt   = low_r;
    crc_nxt   = crc_r;
    count_nxt = count_r;
    err_nxt   = err_r;

    if (accept) begin
      count_nxt = count_eff;
      err_nxt   = err_eff;
      unique case (phase_eff)
        PH_LOW: begin
          low_nxt = in_data.rx_byte;
          crc_nxt = crc8_update(crc_r, in_data.rx_byte);
        end
        PH_CRC: begin
          crc_nxt = CRC_INIT;
          if (last) begin
            count_nxt = '0;
            err_nxt   = 1'b0;
          end else begin
            count_nxt = count_eff + CNT_W'(1);
            err_nxt   = err_eff | ~ok;
          end
        end
        default: begin
          high_nxt = in_data.rx_byte;
          crc_nxt  = crc8_update(CRC_INIT, in_data.rx_byte);
        end
      endcase
    end

    out_data_nxt               = out_data_r;
    out_data_nxt.word_index    = count_ext[2:0];
    out_data_nxt.word_value    = word;
    out_data_nxt.crc_ok        = ok;
    out_data_nxt.not_available = (count_ext < FIRST_SGN) ? (word == SENT_UNSIGNED)
                                                         : (word == SENT_SIGNED);
    out_data_nxt.frame_last    = last;
    out_data_nxt.frame_ok      = last & ~err_eff & ok;
    if (!emit) begin
      out_data_nxt = out_data_r;
    end

    out_valid_nxt = emit | (out_valid_r & out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HIGH;
      count_r     <= '0;
      err_r       <= 1'b0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    high_r     <= high_nxt;
    low_r      <= low_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/crcwd_word_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crcwd_word_checker
// Watches both channels of the word deframer, predicts and compares results.
// ----------------------------------------------------------------------------
// Every byte taken on the input channel goes through an independent model of
// the group and frame counters and the CRC-8. Each byte that closes a group
// queues one expected word. Every word taken on the output channel is
// compared field by field with the oldest queued word. The failure count and
// the number of words still awaited go to the testbench top.
// ----------------------------------------------------------------------------
module crcwd_word_checker #(
  parameter int WORDS_PER_FRAME   = 8,
  parameter int FIRST_SIGNED_WORD = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  crcwd_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  crcwd_pkg::out_item_t out_data,
  output int                   fail_count,
  output int                   pending_count
);
  import crcwd_pkg::*;

  localparam logic [7:0] GEN_POLY = 8'h31;

  // model state
  phase_t     grp_phase;
  int         word_no;
  logic [7:0] hi_byte;
  logic [7:0] lo_byte;
  logic [7:0] crc_acc;
  logic       frame_bad;

  out_item_t  expected_words [$];
  int         fails = 0;
  int         awaited = 0;

  assign fail_count    = fails;
  assign pending_count = awaited;

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ GEN_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // advance the model by one byte, queue a word when a group closes
  task automatic decode_byte(input in_item_t it);
    out_item_t   w;
    logic [15:0] value;
    logic [15:0] sentinel;
    logic        ok;
    logic        last;
    if (it.frame_start) begin
      grp_phase = PH_HIGH;
      word_no   = 0;
      frame_bad = 1'b0;
      crc_acc   = CRC_INIT;
    end
    unique case (grp_phase)
      PH_LOW: begin
        lo_byte   = it.rx_byte;
        crc_acc   = crc8_step(crc_acc, it.rx_byte);
        grp_phase = PH_CRC;
      end
      PH_CRC: begin
        value    = {hi_byte, lo_byte};
        ok       = (crc_acc == it.rx_byte);
        if (!ok) begin
          frame_bad = 1'b1;
        end
        sentinel = (word_no < FIRST_SIGNED_WORD) ? SENT_UNSIGNED : SENT_SIGNED;
        last     = (word_no + 1 >= WORDS_PER_FRAME);
        w.word_index    = word_no[2:0];
        w.word_value    = value;
        w.crc_ok        = ok;
        w.not_available = (value == sentinel);
        w.frame_last    = last;
        w.frame_ok      = last && !frame_bad;
        expected_words.push_back(w);
        if (last) begin
          word_no   = 0;
          frame_bad = 1'b0;
        end else begin
          word_no++;
        end
        grp_phase = PH_HIGH;
        crc_acc   = CRC_INIT;
      end
      default: begin
        hi_byte   = it.rx_byte;
        crc_acc   = crc8_step(CRC_INIT, it.rx_byte);
        grp_phase = PH_LOW;
      end
    endcase
  endtask

  // compare taken words, then predict from the taken byte
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      grp_phase = PH_HIGH;
      word_no   = 0;
      hi_byte   = '0;
      lo_byte   = '0;
      crc_acc   = CRC_INIT;
      frame_bad = 1'b0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result item with no expected word: 0x%0h", out_data);
          fails++;
        end else begin
          want = expected_words.pop_front();
          check_field("word_index", want.word_index, out_data.word_index);
          check_field("word_value", want.word_value, out_data.word_value);
          check_field("crc_ok", want.crc_ok, out_data.crc_ok);
          check_field("not_available", want.not_available, out_data.not_available);
          check_field("frame_last", want.frame_last, out_data.frame_last);
          check_field("frame_ok", want.frame_ok, out_data.frame_ok);
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
      end
    end
    awaited = expected_words.size();
  end

endmodule

// ----- verif/crc_word_response_deframer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_word_response_deframer_unit_tb
// Byte stimulus and verdict for the CRC-8 word deframer.
// ----------------------------------------------------------------------------
// A short directed frame covers the sentinels on both sides of the signed
// boundary, a bad CRC and a frame start in the middle of a group. Random
// traffic follows: mostly whole frames with random words and occasional bad
// CRCs, some frames without a start flag, cut-short frames and loose noise
// bytes. Both sides idle in random bursts; the receiver holds off once for a
// long stretch and the sender pauses once until every word is back. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module crc_word_response_deframer_unit_tb;
  import crcwd_pkg::*;

  localparam int WPF         = 8;
  localparam int FSW         = 4;
  localparam int BYTE_TARGET = 1150;
  localparam int QUIET_FROM  = 950;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int        fail_count;
  int        pending_count;
  int        n_sent = 0;
  logic      gaps_on = 1'b0;
  logic      quiet = 1'b0;
  logic      hold_req = 1'b0;

  crc_word_response_deframer_unit #(
    .WORDS_PER_FRAME  (WPF),
    .FIRST_SIGNED_WORD(FSW)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  crcwd_word_checker #(
    .WORDS_PER_FRAME  (WPF),
    .FIRST_SIGNED_WORD(FSW)
  ) word_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // offer one byte from a falling edge, return at the falling edge after it is taken
  task automatic send_byte(input logic [7:0] b, input logic s);
    if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_data  = '{rx_byte: b, frame_start: s};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_sent++;
  endtask

  // one frame of words with their crc bytes, the first cut bytes of it sent
  task automatic send_frame(input logic with_start, input int cut,
                            input logic [15:0] vals [WPF], input logic [WPF-1:0] bad);
    logic [7:0] bytes [3*WPF];
    logic [7:0] crc;
    for (int i = 0; i < WPF; i++) begin
      crc = crc8_update(crc8_update(CRC_INIT, vals[i][15:8]), vals[i][7:0]);
      if (bad[i]) begin
        crc = crc ^ 8'($urandom_range(1, 255));
      end
      bytes[3*i]   = vals[i][15:8];
      bytes[3*i+1] = vals[i][7:0];
      bytes[3*i+2] = crc;
    end
    for (int k = 0; k < cut; k++) begin
      send_byte(bytes[k], with_start && k == 0);
    end
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return SENT_UNSIGNED;
      1:       return SENT_SIGNED;
      2:       return 16'h0000;
      3:       return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      out_stall = (stall_left > 0);
    end
  end

  // watchdog on cycles with no item taken on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [15:0]    vals [WPF];
    logic [WPF-1:0] bad;
    logic           hold_done;
    logic           pause_done;
    int             kind;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // frame start in the middle of a group, then a frame of edge words
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    vals = '{16'hFFFF, 16'h7FFF, 16'h0000, 16'hBEEF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h00FF};
    send_frame(1'b1, 3*WPF, vals, 8'b0000_1000);

    while (n_sent < BYTE_TARGET) begin
      gaps_on = ($urandom_range(0, 2) != 0);
      if (n_sent > QUIET_FROM) begin
        quiet = 1'b1;
      end
      if (!hold_done && n_sent > 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && n_sent > 600) begin
        in_valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        pause_done = 1'b1;
      end
      for (int i = 0; i < WPF; i++) begin
        vals[i] = pick_word();
        bad[i]  = ($urandom_range(0, 5) == 0);
      end
      if ($urandom_range(0, 1) == 0) begin
        bad = '0;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // whole frame, now and then relying on the wrap instead of a start flag
        send_frame(kind != 0, 3*WPF, vals, bad);
      end else if (kind == 7) begin
        send_frame(1'b1, $urandom_range(1, 3*WPF - 1), vals, bad);
      end else begin
        repeat ($urandom_range(3, 20)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end

    // drain
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
